### design/hzoc_pkg.sv
// ----------------------------------------------------------------------------
// hzoc_pkg
// Shared widths, register indexes, axis codes and the control and status
// structs of the hierarchical z-order address converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hzoc_pkg;

    localparam int MAX_LEVELS_DEF = 32;
    localparam int COORD_W        = 31;
    localparam int LEVEL_W        = 6;
    localparam int PATTERN_W      = 64;
    localparam int CIDX_W         = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int IN_DATA_W      = 128;
    localparam int OUT_DATA_W     = 136;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_PATTERN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z        = 3'd4;

    typedef enum logic [1:0] {
        AX_X    = 2'd0,
        AX_Y    = 2'd1,
        AX_Z    = 2'd2,
        AX_NONE = 2'd3
    } t_axis;

    typedef struct packed {
        logic load;
        logic enc_mix;
        logic enc_strip;
        logic dec_len;
        logic dec_norm;
        logic dec_split;
        logic out_load;
    } t_ctrl;

    typedef struct packed {
        logic lev_zero;
        logic low_bit;
        logic len_zero;
        logic top_bit;
    } t_stat;

    typedef struct packed {
        logic               in_box;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] addr;
    } t_result;

    // axis code that the pattern gives one level
    function automatic t_axis axis_at(input logic [PATTERN_W-1:0] pattern,
                                      input logic [CIDX_W-1:0] lev);
        return t_axis'(pattern[{lev, 1'b0} +: 2]);
    endfunction

endpackage

`default_nettype wire

### design/hzoc_ctrl.sv
// ----------------------------------------------------------------------------
// hzoc_ctrl
// Sequencer: walks one word through the bit-serial phases of the encode or
// decode and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hzoc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_kind,
    input  logic             i_out_free,
    input  hzoc_pkg::t_stat  i_stat,
    output logic             o_ready,
    output hzoc_pkg::t_ctrl  o_ctrl
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_ENC_MIX   = 7'b0000010,
        ST_ENC_STRIP = 7'b0000100,
        ST_DEC_LEN   = 7'b0001000,
        ST_DEC_NORM  = 7'b0010000,
        ST_DEC_SPLIT = 7'b0100000,
        ST_FIN       = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = i_kind ? ST_DEC_LEN : ST_ENC_MIX;
                end
            end
            ST_ENC_MIX: begin
                o_ctrl.enc_mix = 1'b1;
                if (i_stat.lev_zero) begin
                    n_state = ST_ENC_STRIP;
                end
            end
            ST_ENC_STRIP: begin
                // shift out trailing zeros and the lowest set bit
                o_ctrl.enc_strip = 1'b1;
                if (i_stat.low_bit) begin
                    n_state = ST_FIN;
                end
            end
            ST_DEC_LEN: begin
                o_ctrl.dec_len = 1'b1;
                if (i_stat.len_zero) begin
                    n_state = ST_DEC_NORM;
                end
            end
            ST_DEC_NORM: begin
                o_ctrl.dec_norm = 1'b1;
                if (i_stat.top_bit) begin
                    n_state = ST_DEC_SPLIT;
                end
            end
            ST_DEC_SPLIT: begin
                o_ctrl.dec_split = 1'b1;
                if (i_stat.lev_zero) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### design/hzoc_dpath.sv
// ----------------------------------------------------------------------------
// hzoc_dpath
// Shared shift and count datapath: interleaves or scatters one address bit
// per cycle and strips or normalizes the z word one position per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hzoc_dpath #(
    parameter int MAX_LEVELS = hzoc_pkg::MAX_LEVELS_DEF
) (
    input  logic                                i_clk,
    input  hzoc_pkg::t_ctrl                     i_ctrl,
    input  logic                                i_kind,
    input  logic [hzoc_pkg::COORD_W-1:0]        i_coord_x,
    input  logic [hzoc_pkg::COORD_W-1:0]        i_coord_y,
    input  logic [hzoc_pkg::COORD_W-1:0]        i_coord_z,
    input  logic [hzoc_pkg::COORD_W-1:0]        i_hz_address,
    input  logic [hzoc_pkg::PATTERN_W-1:0]      i_axis_pattern,
    input  logic [hzoc_pkg::LEVEL_W-1:0]        i_levels,
    input  logic [hzoc_pkg::COORD_W-1:0]        i_box_x,
    input  logic [hzoc_pkg::COORD_W-1:0]        i_box_y,
    input  logic [hzoc_pkg::COORD_W-1:0]        i_box_z,
    output hzoc_pkg::t_stat                     o_stat,
    output hzoc_pkg::t_result                   o_result
);

    localparam int W     = MAX_LEVELS;
    localparam int IDX_W = $clog2(MAX_LEVELS);
    localparam int CW    = hzoc_pkg::COORD_W;
    localparam int LW    = hzoc_pkg::LEVEL_W;
    localparam int NW    = hzoc_pkg::CIDX_W;

    logic                  r_kind;
    logic [CW-1:0]         r_hz;
    logic [CW-1:0]         r_c   [3];
    logic [NW-1:0]         r_cnt [3];
    logic [W-1:0]          r_work;
    logic [IDX_W-1:0]      r_lev;
    logic [IDX_W-1:0]      r_pos;
    logic [LW-1:0]         r_count;

    logic [IDX_W-1:0]      w_top;
    logic [W-1:0]          w_mask;
    logic [W-1:0]          w_marker;
    hzoc_pkg::t_axis       w_axis;
    logic                  w_mix_bit;
    logic [31:0]           w_work32;

    assign w_top    = IDX_W'(i_levels - LW'(1));
    assign w_marker = {{(W-1){1'b0}}, 1'b1} << w_top;
    assign w_axis   = hzoc_pkg::axis_at(i_axis_pattern, NW'(r_lev));
    assign w_work32 = 32'(r_work);

    always_comb begin
        for (int i = 0; i < W; i++) begin
            w_mask[i] = (LW'(i) < i_levels);
        end
    end

    // coordinate bit that the current level takes
    always_comb begin
        w_mix_bit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (w_axis == hzoc_pkg::t_axis'(k) && r_cnt[k] < NW'(CW)) begin
                w_mix_bit = r_c[k][r_cnt[k]];
            end
        end
    end

    assign o_stat.lev_zero = (r_lev == '0);
    assign o_stat.low_bit  = r_work[0];
    assign o_stat.len_zero = (r_c[0] == '0);
    assign o_stat.top_bit  = r_work[w_top];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_kind  <= i_kind;
            r_hz    <= i_hz_address;
            r_lev   <= w_top;
            r_pos   <= '0;
            r_count <= '0;
            for (int k = 0; k < 3; k++) begin
                r_cnt[k] <= '0;
            end
            if (i_kind) begin
                // x register doubles as the bit length scanner
                r_c[0] <= i_hz_address;
                r_c[1] <= '0;
                r_c[2] <= '0;
                r_work <= W'({i_hz_address, 1'b1}) & w_mask;
            end else begin
                r_c[0] <= i_coord_x;
                r_c[1] <= i_coord_y;
                r_c[2] <= i_coord_z;
                r_work <= w_marker;
            end
        end

        if (i_ctrl.enc_mix && !o_stat.lev_zero) begin
            r_work[r_pos] <= w_mix_bit;
            for (int k = 0; k < 3; k++) begin
                if (w_axis == hzoc_pkg::t_axis'(k)) begin
                    r_cnt[k] <= r_cnt[k] + NW'(1);
                end
            end
            r_pos <= r_pos + IDX_W'(1);
            r_lev <= r_lev - IDX_W'(1);
        end

        if (i_ctrl.enc_strip) begin
            r_work  <= r_work >> 1;
            r_count <= r_count + LW'(1);
        end

        if (i_ctrl.dec_len && !o_stat.len_zero) begin
            r_c[0]  <= r_c[0] >> 1;
            r_count <= r_count + LW'(1);
        end

        if (i_ctrl.dec_norm) begin
            if (o_stat.top_bit) begin
                r_work[w_top] <= 1'b0;
            end else begin
                r_work <= r_work << 1;
            end
        end

        if (i_ctrl.dec_split && !o_stat.lev_zero) begin
            for (int k = 0; k < 3; k++) begin
                if (w_axis == hzoc_pkg::t_axis'(k)) begin
                    if (r_cnt[k] < NW'(CW)) begin
                        r_c[k][r_cnt[k]] <= r_work[0];
                    end
                    r_cnt[k] <= r_cnt[k] + NW'(1);
                end
            end
            r_work <= r_work >> 1;
            r_lev  <= r_lev - IDX_W'(1);
        end
    end

    assign o_result.addr   = r_kind ? r_hz : w_work32[CW-1:0];
    assign o_result.level  = r_kind ? r_count : (i_levels - r_count);
    assign o_result.x      = r_c[0];
    assign o_result.y      = r_c[1];
    assign o_result.z      = r_c[2];
    assign o_result.in_box = r_kind && (r_c[0] < i_box_x) && (r_c[1] < i_box_y)
                             && (r_c[2] < i_box_z);

`ifndef SYNTHESIS
    // the marker bit keeps the strip loop finite
    a_strip_nonzero: assert property (@(posedge i_clk)
        i_ctrl.enc_strip |-> (r_work != '0))
        else $error("strip phase on an all-zero z word");

    a_mix_position: assert property (@(posedge i_clk)
        i_ctrl.enc_mix |-> ((int'(r_pos) + int'(r_lev)) == int'(w_top)))
        else $error("interleave position out of step with level");

    a_split_count: assert property (@(posedge i_clk)
        i_ctrl.dec_split |-> ((int'(r_cnt[0]) + int'(r_cnt[1]) + int'(r_cnt[2])
                               + int'(r_lev)) <= int'(w_top)))
        else $error("scatter took more bits than levels");
`endif

endmodule

`default_nettype wire

### design/hz_order_address_converter.sv
// ----------------------------------------------------------------------------
// hz_order_address_converter
// Converts 3D sample coordinates to hierarchical z-order addresses and back,
// with a programmable per-level axis pattern and level count.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  s        in         i_s_tvalid/o_s_tready  i_s_tdata, i_s_tuser (kind)
//  m        out        o_m_tvalid/i_m_tready  o_m_tdata
//  cfg      in         i_cfg_wr_en            i_cfg_index, i_cfg_wdata
//
//  h is the clamped level count. encode: one interleave step per level, then
//  one strip shift per trailing bit of the z word.
//  decode: a bit length scan of the address, then k normalizing shifts
//  (at most h-1) and the scatter, all through the one shift/count path.
//  reset (synchronous, active low) clears the sequencer, the result valid
//  and the configuration registers to their defaults.
//  a stalled result holds in the output register; the next word is taken
//  meanwhile and waits in the final step until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module hz_order_address_converter #(
    parameter int MAX_LEVELS = hzoc_pkg::MAX_LEVELS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // coord_x[30:0], coord_y[61:31], coord_z[92:62], hz_address_in[123:93]
    input  logic [hzoc_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // kind[0]
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // hz_address_out[30:0], hz_level[36:31], out_x[67:37], out_y[98:68],
    // out_z[129:99], inside_box[130]
    output logic [hzoc_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input  logic                                 i_cfg_wr_en,
    input  logic [hzoc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hzoc_pkg::PATTERN_W-1:0]       i_cfg_wdata
);

    localparam int CW = hzoc_pkg::COORD_W;
    localparam int LW = hzoc_pkg::LEVEL_W;
    localparam int OW = hzoc_pkg::OUT_DATA_W;

    logic [hzoc_pkg::PATTERN_W-1:0] r_axis_pattern;
    logic [LW-1:0]                  r_level_count;
    logic [CW-1:0]                  r_box_x;
    logic [CW-1:0]                  r_box_y;
    logic [CW-1:0]                  r_box_z;
    logic                           r_out_valid;
    logic [OW-1:0]                  r_out_data;

    logic [LW-1:0]                  w_levels;
    logic                           w_out_free;
    hzoc_pkg::t_ctrl                w_ctrl;
    hzoc_pkg::t_stat                w_stat;
    hzoc_pkg::t_result              w_result;

    always_comb begin
        if (r_level_count == '0) begin
            w_levels = LW'(1);
        end else if (r_level_count > LW'(MAX_LEVELS)) begin
            w_levels = LW'(MAX_LEVELS);
        end else begin
            w_levels = r_level_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_pattern <= '0;
            r_level_count  <= LW'(1);
            r_box_x        <= '0;
            r_box_y        <= '0;
            r_box_z        <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                hzoc_pkg::CFG_AXIS_PATTERN: r_axis_pattern <= i_cfg_wdata;
                hzoc_pkg::CFG_LEVEL_COUNT:  r_level_count  <= i_cfg_wdata[LW-1:0];
                hzoc_pkg::CFG_BOX_X:        r_box_x        <= i_cfg_wdata[CW-1:0];
                hzoc_pkg::CFG_BOX_Y:        r_box_y        <= i_cfg_wdata[CW-1:0];
                hzoc_pkg::CFG_BOX_Z:        r_box_z        <= i_cfg_wdata[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_m_tready;

    hzoc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_ready    (o_s_tready),
        .o_ctrl     (w_ctrl)
    );

    hzoc_dpath #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_ctrl         (w_ctrl),
        .i_kind         (i_s_tuser),
        .i_coord_x      (i_s_tdata[30:0]),
        .i_coord_y      (i_s_tdata[61:31]),
        .i_coord_z      (i_s_tdata[92:62]),
        .i_hz_address   (i_s_tdata[123:93]),
        .i_axis_pattern (r_axis_pattern),
        .i_levels       (w_levels),
        .i_box_x        (r_box_x),
        .i_box_y        (r_box_y),
        .i_box_z        (r_box_z),
        .o_stat         (w_stat),
        .o_result       (w_result)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_load) begin
            r_out_data <= {5'b0, w_result.in_box, w_result.z, w_result.y, w_result.x,
                           w_result.level, w_result.addr};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken again before the word was converted");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_load |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten while occupied");

    a_load_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_load |=> (o_m_tvalid && o_s_tready))
        else $error("result handoff did not return to idle with valid output");
`endif

endmodule

`default_nettype wire
